// File: design/ptrf_pkg.sv
// Package for the page table with round-robin frame allocation.
// Holds field widths, the request type codes and the frame type.
// No dependencies; compiled first.
`default_nettype none

package ptrf_pkg;

    localparam int FRAME_W = 8;
    localparam int TYPE_W  = 2;
    localparam int VPAGE_W = 12;

    typedef enum logic [TYPE_W-1:0] {
        REQ_MAP     = 2'd0,
        REQ_UNMAP   = 2'd1,
        REQ_LOOKUP  = 2'd2,
        REQ_GET_MAP = 2'd3
    } t_req_type;

    typedef logic [FRAME_W-1:0] t_frame;

    localparam t_frame FRAME_NONE  = t_frame'(0);
    localparam t_frame FRAME_FIRST = t_frame'(1);
    localparam t_frame LIMIT_RESET = t_frame'(255);

endpackage

`default_nettype wire

// File: design/ptrf_if.sv
// Valid/ready channels of the page table: request item in, response item out.
// Depends on ptrf_pkg for the field widths.
`default_nettype none

interface ptrf_req_if
    import ptrf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [TYPE_W-1:0]    req_type;
    logic [VPAGE_W-1:0]   virt_page;

    modport source (output valid, output req_type, output virt_page, input ready);
    modport sink   (input valid, input req_type, input virt_page, output ready);
endinterface

interface ptrf_rsp_if
    import ptrf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [FRAME_W-1:0]   frame;
    logic                 ok;

    modport source (output valid, output frame, output ok, input ready);
    modport sink   (input valid, input frame, input ok, output ready);
endinterface

`default_nettype wire

// File: design/page_table_with_round_robin_frames.sv
// Page table with round-robin frame allocation: top level and only module.
// Depends on ptrf_pkg and on the channel interfaces in ptrf_if.sv.
`default_nettype none

// Each request item maps, unmaps, looks up, or looks up and maps a virtual
// page; every item yields exactly one response item (frame, ok). The page
// store (one frame per page, 2**(3*LEVEL_BITS) entries) is a synchronous RAM
// and is zeroed by a clearing pass after reset during which no request is
// accepted; the frame_limit register can be written at any time, including
// during that pass. The owner store (frame -> page) is a RAM plus one valid
// flop per frame, cleared at once by reset. Items are handled one at a time.
// For lookup, unmap, a get-or-map hit and a map whose frame has no owner,
// the accept cycle issues the page-store read, the next cycle decides and
// writes back. A map whose frame still has an owner makes one more read to
// fetch the owner's page entry, and since the page store has a single write
// port, clearing the evicted page and writing the new entry are done in
// separate states (S_EV, then S_WR).
// The allocator hands out frames 1..frame_limit round-robin, first frame 2.
// A response that is not taken stalls the block after the next item finishes.
module page_table_with_round_robin_frames
    import ptrf_pkg::*;
#(
    parameter int LEVEL_BITS = 4,
    parameter int NUM_FRAMES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ptrf_req_if.sink           i_req,
    ptrf_rsp_if.source         o_rsp,
    input  logic               i_cfg_we,
    input  logic [FRAME_W-1:0] i_cfg_wdata
);

    localparam int PAGE_BITS = 3 * LEVEL_BITS;
    localparam int PAGES     = 2 ** PAGE_BITS;
    // frames are 8 bits wide, so no more than 256 owner entries can be used
    localparam int OWN_DEPTH = (NUM_FRAMES < 256) ? NUM_FRAMES : 256;
    localparam int OWN_W     = $clog2(OWN_DEPTH);
    localparam logic [FRAME_W:0] OWN_LIM = (FRAME_W + 1)'(OWN_DEPTH);
    localparam logic [PAGE_BITS-1:0] LAST_PAGE = {PAGE_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_EV,
        S_WR,
        S_HOLD
    } t_state;

    // frame has an entry in the owner store
    function automatic logic has_owner_slot(input t_frame f);
        has_owner_slot = ({1'b0, f} < OWN_LIM);
    endfunction

    // ---------------------------------------------------------------- state
    t_state                 r_state, n_state;
    logic [PAGE_BITS-1:0]   r_clr_addr;
    t_req_type              r_type;
    logic [PAGE_BITS-1:0]   r_page;
    t_frame                 r_f;          // candidate frame of this item
    t_frame                 r_next;       // last frame handed out
    t_frame                 r_limit;      // frame_limit register
    logic                   r_out_valid;
    t_frame                 r_out_frame;
    logic                   r_out_ok;
    t_frame                 r_res_frame;  // finished result waiting for the output
    logic                   r_res_ok;
    logic [OWN_DEPTH-1:0]   r_own_vld;

    // memories and their registered read data
    t_frame                 m_page_ent [PAGES];
    logic [PAGE_BITS-1:0]   m_owner    [OWN_DEPTH];
    t_frame                 r_pe_rd;
    logic [PAGE_BITS-1:0]   r_own_rd;

    // ---------------------------------------------------------------- control
    logic                   w_accept;
    logic [PAGE_BITS-1:0]   w_in_page;
    t_frame                 w_next_f;
    logic                   w_out_free;
    logic                   w_pe_re;
    logic [PAGE_BITS-1:0]   w_pe_raddr;
    logic                   w_pe_we;
    logic [PAGE_BITS-1:0]   w_pe_waddr;
    t_frame                 w_pe_wdata;
    logic                   w_own_set;
    logic                   w_vld_clr;
    t_frame                 w_vld_clr_f;
    logic                   w_take;       // allocator advances
    logic                   w_fin;
    t_frame                 w_res_frame;
    logic                   w_res_ok;
    logic                   w_load;
    t_frame                 w_load_frame;
    logic                   w_load_ok;
    logic                   w_evict;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_page   = PAGE_BITS'(i_req.virt_page);
    assign w_next_f    = (r_next >= r_limit) ? FRAME_FIRST : (r_next + FRAME_FIRST);
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_evict     = has_owner_slot(r_f) && r_own_vld[r_f[OWN_W-1:0]];

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.frame = r_out_frame;
    assign o_rsp.ok    = r_out_ok;

    always_comb begin
        n_state      = r_state;
        w_pe_re      = w_accept;
        w_pe_raddr   = w_in_page;
        w_pe_we      = 1'b0;
        w_pe_waddr   = r_page;
        w_pe_wdata   = FRAME_NONE;
        w_own_set    = 1'b0;
        w_vld_clr    = 1'b0;
        w_vld_clr_f  = r_pe_rd;
        w_take       = 1'b0;
        w_fin        = 1'b0;
        w_res_frame  = FRAME_NONE;
        w_res_ok     = 1'b0;

        case (r_state)
            S_CLR: begin
                // zero one page entry a cycle
                w_pe_we    = 1'b1;
                w_pe_waddr = r_clr_addr;
                if (r_clr_addr == LAST_PAGE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                case (r_type)
                    REQ_UNMAP: begin
                        if (r_pe_rd != FRAME_NONE) begin
                            w_pe_we   = 1'b1;
                            w_vld_clr = has_owner_slot(r_pe_rd);
                        end
                        w_fin    = 1'b1;
                        w_res_ok = (r_pe_rd != FRAME_NONE);
                    end
                    REQ_LOOKUP: begin
                        w_fin       = 1'b1;
                        w_res_frame = r_pe_rd;
                        w_res_ok    = (r_pe_rd != FRAME_NONE);
                    end
                    REQ_MAP, REQ_GET_MAP: begin
                        if (r_type == REQ_GET_MAP && r_pe_rd != FRAME_NONE) begin
                            // already mapped: return it
                            w_fin       = 1'b1;
                            w_res_frame = r_pe_rd;
                            w_res_ok    = 1'b1;
                        end else begin
                            w_take = 1'b1;
                            if (w_evict) begin
                                // fetch the owner page's entry first
                                w_pe_re    = 1'b1;
                                w_pe_raddr = r_own_rd;
                                n_state    = S_EV;
                            end else begin
                                w_pe_we     = 1'b1;
                                w_pe_wdata  = r_f;
                                w_own_set   = has_owner_slot(r_f);
                                w_fin       = 1'b1;
                                w_res_frame = r_f;
                                w_res_ok    = 1'b1;
                            end
                        end
                    end
                    default: begin
                        w_fin = 1'b1;
                    end
                endcase
            end
            S_EV: begin
                // drop the evicted page if it still holds a frame
                if (r_pe_rd != FRAME_NONE) begin
                    w_pe_we    = 1'b1;
                    w_pe_waddr = r_own_rd;
                    w_vld_clr  = has_owner_slot(r_pe_rd);
                end
                n_state = S_WR;
            end
            S_WR: begin
                w_pe_we     = 1'b1;
                w_pe_wdata  = r_f;
                w_own_set   = has_owner_slot(r_f);
                w_fin       = 1'b1;
                w_res_frame = r_f;
                w_res_ok    = 1'b1;
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            n_state = w_out_free ? S_IDLE : S_HOLD;
        end
    end

    assign w_load       = (w_fin || r_state == S_HOLD) && w_out_free;
    assign w_load_frame = (r_state == S_HOLD) ? r_res_frame : w_res_frame;
    assign w_load_ok    = (r_state == S_HOLD) ? r_res_ok    : w_res_ok;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_next      <= FRAME_FIRST;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_own_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + PAGE_BITS'(1);
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_type <= t_req_type'(i_req.req_type);
                r_page <= w_in_page;
                r_f    <= w_next_f;
            end
            if (w_take) begin
                r_next <= r_f;
            end
            // clear before set: a frame evicted and reused in one item stays owned
            if (w_vld_clr) begin
                r_own_vld[w_vld_clr_f[OWN_W-1:0]] <= 1'b0;
            end
            if (w_own_set) begin
                r_own_vld[r_f[OWN_W-1:0]] <= 1'b1;
            end
            if (w_fin && !w_out_free) begin
                r_res_frame <= w_res_frame;
                r_res_ok    <= w_res_ok;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_frame <= w_load_frame;
                r_out_ok    <= w_load_ok;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // page store: one write port, one read port, registered read
    always_ff @(posedge i_clk) begin
        if (w_pe_we) begin
            m_page_ent[w_pe_waddr] <= w_pe_wdata;
        end
        if (w_pe_re) begin
            r_pe_rd <= m_page_ent[w_pe_raddr];
        end
    end

    // owner store: page that owns each frame, read at accept
    always_ff @(posedge i_clk) begin
        if (w_own_set) begin
            m_owner[r_f[OWN_W-1:0]] <= r_page;
        end
        if (w_accept) begin
            r_own_rd <= m_owner[w_next_f[OWN_W-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_next_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next != FRAME_NONE)
        else $error("allocator holds frame 0");

    a_miss_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ok) |-> (o_rsp.frame == FRAME_NONE))
        else $error("response without ok carries a frame");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while the previous one is in work");

    a_owner_matches_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_own_set |-> (w_pe_we && w_pe_wdata == r_f && w_pe_waddr == r_page))
        else $error("owner record written without its page entry");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for page_table_with_round_robin_frames.
// Drives request items, checks every response item against an in-bench page table model.
// Depends on ptrf_pkg and the channel interfaces in ptrf_if.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ptrf_pkg::*;

    localparam int PAGE_COUNT  = 1 << VPAGE_W;
    localparam int FRAME_COUNT = 1 << FRAME_W;
    localparam int DIR_ROWS    = 30;
    // Response item at which the receiver holds off for a long stretch.
    localparam int HOLD_AT     = 450;
    localparam int HOLD_CYCLES = 300;
    // Clearing pass plus ~1230 items at worst-case gaps, stalls and block
    // processing, the long hold and the drain pauses, taken several times.
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_PAUSE = 8;

    // One row of the directed table: either a frame_limit write or a request.
    // Where typed is set, the expected response is read straight from the row.
    typedef struct packed {
        logic               is_cfg;
        t_frame             cfg_val;
        t_req_type          kind;
        logic [VPAGE_W-1:0] page;
        logic               typed;
        t_frame             exp_frame;
        logic               exp_ok;
    } t_dir_row;

    typedef struct packed {
        t_frame frame;
        logic   ok;
    } t_rsp;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [FRAME_W-1:0] i_cfg_wdata;

    ptrf_req_if req_ch ();
    ptrf_rsp_if rsp_ch ();

    page_table_with_round_robin_frames #(
        .LEVEL_BITS (4),
        .NUM_FRAMES (FRAME_COUNT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Responses due from the block, oldest first.
    t_rsp rsp_due [$];
    int   mismatches = 0;
    int   rsp_seen   = 0;
    int   cycles     = 0;
    bit   sender_idles;
    bit   receiver_idles;

    // ------------------------------------------------------------------
    // Page table model: forward store (page -> frame, 0 = unmapped),
    // reverse store (frame -> owning page), round-robin allocator.
    // ------------------------------------------------------------------
    t_frame             pt_frame_of [PAGE_COUNT];
    logic               pt_owned    [FRAME_COUNT];
    logic [VPAGE_W-1:0] pt_owner    [FRAME_COUNT];
    t_frame             pt_alloc;
    t_frame             pt_limit;

    // Drop a page's mapping and free its frame; report whether one existed.
    function automatic logic pt_unmap(input logic [VPAGE_W-1:0] page);
        t_frame f;
        f = pt_frame_of[page];
        if (f == FRAME_NONE)
            return 1'b0;
        pt_owned[f]       = 1'b0;
        pt_owner[f]       = '0;
        pt_frame_of[page] = FRAME_NONE;
        return 1'b1;
    endfunction

    // Take the next frame round-robin. If it still has an owner, unmap that
    // owner first, whatever frame the owner holds now (stale after a remap).
    function automatic t_frame pt_map(input logic [VPAGE_W-1:0] page);
        t_frame f;
        f = (pt_alloc >= pt_limit) ? FRAME_FIRST : t_frame'(pt_alloc + 1'b1);
        pt_alloc = f;
        if (pt_owned[f])
            void'(pt_unmap(pt_owner[f]));
        pt_frame_of[page] = f;
        pt_owned[f]       = 1'b1;
        pt_owner[f]       = page;
        return f;
    endfunction

    function automatic t_rsp pt_step(input t_req_type kind, input logic [VPAGE_W-1:0] page);
        t_rsp r;
        r.frame = FRAME_NONE;
        r.ok    = 1'b0;
        case (kind)
            REQ_MAP: begin
                r.frame = pt_map(page);
                r.ok    = 1'b1;
            end
            REQ_UNMAP: begin
                r.ok = pt_unmap(page);
            end
            REQ_LOOKUP: begin
                r.frame = pt_frame_of[page];
                r.ok    = (r.frame != FRAME_NONE);
            end
            default: begin
                r.frame = pt_frame_of[page];
                if (r.frame == FRAME_NONE)
                    r.frame = pt_map(page);
                r.ok = 1'b1;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic t_dir_row req_row(input t_req_type kind, input logic [VPAGE_W-1:0] page);
        return '{1'b0, FRAME_NONE, kind, page, 1'b0, FRAME_NONE, 1'b0};
    endfunction

    function automatic t_dir_row typed_row(input t_req_type kind, input logic [VPAGE_W-1:0] page,
                                           input t_frame f, input logic ok);
        return '{1'b0, FRAME_NONE, kind, page, 1'b1, f, ok};
    endfunction

    function automatic t_dir_row cfg_row(input t_frame v);
        return '{1'b1, v, REQ_LOOKUP, {VPAGE_W{1'b0}}, 1'b0, FRAME_NONE, 1'b0};
    endfunction

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one request item, after a random gap when sender_idles is set; hold
    // it until accepted, then run the model on it and queue the response it owes.
    task automatic send_req(input t_req_type kind, input logic [VPAGE_W-1:0] page,
                            input logic typed, input t_frame exp_frame, input logic exp_ok);
        int   gap;
        t_rsp due;
        gap = sender_idles ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.virt_page <= page;
        do @(posedge i_clk); while (!req_ch.ready);
        due = pt_step(kind, page);
        // Keep the model's state either way; take the typed value where given.
        if (typed) begin
            due.frame = exp_frame;
            due.ok    = exp_ok;
        end
        rsp_due.push_back(due);
    endtask

    // Stop offering, wait for every owed response, then let the block settle.
    task automatic drain;
        req_ch.valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // Write frame_limit for one cycle; only called with the block idle.
    task automatic write_limit(input t_frame v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pt_limit     = v;
    endtask

    // One random phase: set the limit, then mostly hit a small working set of
    // pages so that lookups hit, remaps leave stale owners and evictions occur.
    task automatic run_random(input t_frame limit, input bit idles, input int count);
        logic [VPAGE_W-1:0] hot [32];
        logic [VPAGE_W-1:0] page;
        t_req_type          kind;
        int                 r;
        for (int i = 0; i < 32; i++)
            hot[i] = VPAGE_W'($urandom_range(0, PAGE_COUNT - 1));
        drain();
        write_limit(limit);
        sender_idles   = idles;
        receiver_idles = idles;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                kind = REQ_MAP;
            else if (r < 50)
                kind = REQ_UNMAP;
            else if (r < 75)
                kind = REQ_LOOKUP;
            else
                kind = REQ_GET_MAP;
            // Refresh the working set now and then.
            if ($urandom_range(0, 19) == 0)
                hot[$urandom_range(0, 31)] = VPAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            if ($urandom_range(0, 3) != 0)
                page = hot[$urandom_range(0, 31)];
            else
                page = VPAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            send_req(kind, page, 1'b0, FRAME_NONE, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, one long hold-off, field-by-field check
    // ------------------------------------------------------------------
    initial begin : rsp_side
        int   stall;
        t_rsp want;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = receiver_idles ? $urandom_range(0, 4) : 0;
            // Hold off long enough for the block to back up and stall its input.
            if (rsp_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            rsp_seen++;
            if (rsp_due.size() == 0) begin
                $error("response item with no request pending: frame %0d ok %0d",
                       rsp_ch.frame, rsp_ch.ok);
                mismatches++;
            end else begin
                want = rsp_due.pop_front();
                if (rsp_ch.frame !== want.frame) begin
                    $error("frame: expected %0d, actual %0d", want.frame, rsp_ch.frame);
                    mismatches++;
                end
                if (rsp_ch.ok !== want.ok) begin
                    $error("ok: expected %0d, actual %0d", want.ok, rsp_ch.ok);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_dir_row rows [DIR_ROWS];

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_MAP;
        req_ch.virt_page = '0;
        sender_idles     = 1'b1;
        receiver_idles   = 1'b1;

        // Model state after reset: nothing mapped, no owners, allocator at 1.
        for (int p = 0; p < PAGE_COUNT; p++)
            pt_frame_of[p] = FRAME_NONE;
        for (int f = 0; f < FRAME_COUNT; f++) begin
            pt_owned[f] = 1'b0;
            pt_owner[f] = '0;
        end
        pt_alloc = FRAME_FIRST;
        pt_limit = LIMIT_RESET;

        rows = '{
            // Empty table after reset: misses everywhere.
            typed_row(REQ_LOOKUP,  12'h000, FRAME_NONE, 1'b0),
            typed_row(REQ_UNMAP,   12'hFFF, FRAME_NONE, 1'b0),
            typed_row(REQ_LOOKUP,  12'hFFF, FRAME_NONE, 1'b0),
            // First frame handed out is 2, then 3.
            typed_row(REQ_MAP,     12'h000, 8'd2,       1'b1),
            typed_row(REQ_MAP,     12'hFFF, 8'd3,       1'b1),
            typed_row(REQ_LOOKUP,  12'hFFF, 8'd3,       1'b1),
            // Get-or-map: hit returns the frame, miss maps a new one.
            typed_row(REQ_GET_MAP, 12'h000, 8'd2,       1'b1),
            typed_row(REQ_GET_MAP, 12'hABC, 8'd4,       1'b1),
            // Remap page 0: frame 2 keeps page 0 as a stale owner.
            req_row(REQ_MAP,       12'h000),
            req_row(REQ_LOOKUP,    12'h000),
            typed_row(REQ_UNMAP,   12'hFFF, FRAME_NONE, 1'b1),
            typed_row(REQ_UNMAP,   12'hFFF, FRAME_NONE, 1'b0),
            typed_row(REQ_LOOKUP,  12'h555, FRAME_NONE, 1'b0),
            // Lower the limit below the allocator: it wraps to frame 1.
            cfg_row(8'd4),
            req_row(REQ_MAP,       12'h123),
            // Frame 2 is stale: page 0 loses the frame it holds now.
            req_row(REQ_MAP,       12'h124),
            req_row(REQ_LOOKUP,    12'h000),
            // Frame 3 was freed by the unmap: no eviction.
            req_row(REQ_MAP,       12'h125),
            // Frame 4 still owned: evict page ABC.
            req_row(REQ_MAP,       12'h126),
            req_row(REQ_LOOKUP,    12'hABC),
            // Owner of frame 1 goes unmapped before the allocator comes back.
            req_row(REQ_MAP,       12'h200),
            req_row(REQ_MAP,       12'h200),
            req_row(REQ_UNMAP,     12'h200),
            req_row(REQ_MAP,       12'h300),
            req_row(REQ_MAP,       12'h301),
            req_row(REQ_MAP,       12'h302),
            req_row(REQ_LOOKUP,    12'h302),
            // Smallest limit: every map takes frame 1.
            cfg_row(8'd1),
            req_row(REQ_GET_MAP,   12'hAAA),
            req_row(REQ_LOOKUP,    12'h302)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; the block's clearing pass holds off the first item.
        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                drain();
                write_limit(rows[k].cfg_val);
            end else begin
                send_req(rows[k].kind, rows[k].page, rows[k].typed,
                         rows[k].exp_frame, rows[k].exp_ok);
            end
        end

        // Random phases over several limits, the extremes among them; idling is
        // off in some phases so that those stretches run back to back.
        run_random(LIMIT_RESET, 1'b1, 200);
        run_random(8'd1,        1'b0, 200);
        run_random(8'd2,        1'b1, 200);
        run_random(8'd13,       1'b1, 200);
        run_random(8'd128,      1'b0, 200);
        run_random(t_frame'($urandom_range(3, 254)), 1'b1, 200);

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
design/ptrf_pkg.sv
design/ptrf_if.sv
design/page_table_with_round_robin_frames.sv
tb/tb_top.sv
